// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the engine's datapath module
// Concurrent checks sampled on the rising clock edge.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check while out of reset
`define IALE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("iale assertion failed");
// Check at every edge, reset included
`define IALE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
    else $error("iale assertion failed");
`else
`define IALE_ASSERT(name, clk, rst_n, prop)
`define IALE_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- hdl/iale_pkg.sv -----
// ---------------------------------------------------------------------------
// iale_pkg
// Types, codes and sizes shared by the array list engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package iale_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int POS_W      = 7;
    localparam int EXT_W      = POS_W + 1;

    localparam logic [3:0] CMD_PUSH        = 4'd0;
    localparam logic [3:0] CMD_POP         = 4'd1;
    localparam logic [3:0] CMD_INSERT      = 4'd2;
    localparam logic [3:0] CMD_ERASE_ONE   = 4'd3;
    localparam logic [3:0] CMD_ERASE_RANGE = 4'd4;
    localparam logic [3:0] CMD_READ        = 4'd5;
    localparam logic [3:0] CMD_WRITE       = 4'd6;
    localparam logic [3:0] CMD_CLEAR       = 4'd7;
    localparam logic [3:0] CMD_RESIZE      = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [3:0]            cmd;
        logic [POS_W-1:0]      position;
        logic [POS_W-1:0]      range_end;
        logic [POS_W-1:0]      amount;
        logic [WORD_WIDTH-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [WORD_WIDTH-1:0] read_value;
        logic [POS_W-1:0]      result_position;
        logic [POS_W-1:0]      length;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic plan;
        logic mem_rd;
        logic move_wr;
        logic fill_wr;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rd_pending;
        logic moves_left;
        logic fills_left;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- hdl/iale_dp.sv -----
// ---------------------------------------------------------------------------
// iale_dp
// Word storage, length, move and fill pointers, and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iale_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  iale_pkg::req_t     req,
    input  iale_pkg::ctrl_cmd_t cmd,
    output iale_pkg::dp_stat_t stat,
    input  logic               rsp_stall,
    output logic               rsp_valid,
    output iale_pkg::rsp_t     rsp
);

    logic [iale_pkg::WORD_WIDTH-1:0] mem [iale_pkg::CAPACITY];

    iale_pkg::req_t                  item_reg;
    logic [iale_pkg::POS_W-1:0]      len_reg;
    logic [iale_pkg::POS_W-1:0]      src_reg;
    logic [iale_pkg::POS_W-1:0]      dst_reg;
    logic [iale_pkg::POS_W-1:0]      fptr_reg;
    logic [iale_pkg::POS_W-1:0]      mcnt_reg;
    logic [iale_pkg::POS_W-1:0]      fcnt_reg;
    logic                            up_reg;
    logic                            rd_pending_reg;
    logic                            rd_op_reg;
    logic [1:0]                      status_reg;
    logic [iale_pkg::POS_W-1:0]      rpos_reg;
    logic [iale_pkg::WORD_WIDTH-1:0] rdata_reg;
    logic                            out_valid_reg;
    iale_pkg::rsp_t                  rsp_reg;

    logic [1:0]                 p_status;
    logic [iale_pkg::POS_W-1:0] p_pos;
    logic [iale_pkg::POS_W-1:0] p_len;
    logic [iale_pkg::POS_W-1:0] p_mcnt;
    logic [iale_pkg::POS_W-1:0] p_src;
    logic [iale_pkg::POS_W-1:0] p_dst;
    logic                       p_up;
    logic [iale_pkg::POS_W-1:0] p_fptr;
    logic [iale_pkg::POS_W-1:0] p_fcnt;
    logic                       p_rd;

    logic [iale_pkg::EXT_W-1:0] len_e;
    logic [iale_pkg::EXT_W-1:0] pos_e;
    logic [iale_pkg::EXT_W-1:0] rend_e;
    logic [iale_pkg::EXT_W-1:0] amt_e;
    logic [iale_pkg::EXT_W-1:0] stop_e;
    logic [iale_pkg::EXT_W-1:0] cap_e;
    logic [iale_pkg::EXT_W-1:0] tmp_e;

    logic                            we;
    logic [iale_pkg::ADDR_W-1:0]     waddr;
    logic [iale_pkg::ADDR_W-1:0]     raddr;
    logic [iale_pkg::WORD_WIDTH-1:0] wdata;

    // Work out status, pointers and counts for the captured command
    always_comb
    begin
        len_e  = {1'b0, len_reg};
        pos_e  = {1'b0, item_reg.position};
        rend_e = {1'b0, item_reg.range_end};
        amt_e  = {1'b0, item_reg.amount};
        cap_e  = iale_pkg::EXT_W'(iale_pkg::CAPACITY);
        stop_e = (item_reg.cmd == iale_pkg::CMD_ERASE_ONE) ? pos_e + 1'b1 : rend_e;
        tmp_e  = '0;
        p_status = iale_pkg::ST_OK;
        p_pos    = '0;
        p_len    = len_reg;
        p_mcnt   = '0;
        p_src    = '0;
        p_dst    = '0;
        p_up     = 1'b0;
        p_fptr   = '0;
        p_fcnt   = '0;
        p_rd     = 1'b0;
        unique case (item_reg.cmd)
            iale_pkg::CMD_PUSH:
            begin
                if (len_e >= cap_e)
                begin
                    p_status = iale_pkg::ST_FULL;
                end
                else
                begin
                    p_fptr = len_reg;
                    p_fcnt = iale_pkg::POS_W'(1);
                    p_pos  = len_reg;
                    p_len  = len_reg + 1'b1;
                end
            end
            iale_pkg::CMD_POP:
            begin
                if (len_reg == '0)
                    p_status = iale_pkg::ST_EMPTY;
                else
                    p_len = len_reg - 1'b1;
            end
            iale_pkg::CMD_INSERT:
            begin
                if (pos_e > len_e)
                begin
                    p_status = iale_pkg::ST_RANGE;
                end
                else if (len_e + amt_e > cap_e)
                begin
                    p_status = iale_pkg::ST_FULL;
                end
                else
                begin
                    tmp_e  = len_e - pos_e;
                    p_mcnt = tmp_e[iale_pkg::POS_W-1:0];
                    p_src  = len_reg - 1'b1;
                    p_dst  = len_reg - 1'b1 + item_reg.amount;
                    p_fptr = item_reg.position;
                    p_fcnt = item_reg.amount;
                    p_len  = len_reg + item_reg.amount;
                    p_pos  = item_reg.position;
                end
            end
            iale_pkg::CMD_ERASE_ONE, iale_pkg::CMD_ERASE_RANGE:
            begin
                if (pos_e > stop_e || stop_e > len_e)
                begin
                    p_status = iale_pkg::ST_RANGE;
                end
                else
                begin
                    tmp_e  = len_e - stop_e;
                    p_mcnt = tmp_e[iale_pkg::POS_W-1:0];
                    p_src  = stop_e[iale_pkg::POS_W-1:0];
                    p_dst  = item_reg.position;
                    p_up   = 1'b1;
                    tmp_e  = len_e - (stop_e - pos_e);
                    p_len  = tmp_e[iale_pkg::POS_W-1:0];
                    p_pos  = item_reg.position;
                end
            end
            iale_pkg::CMD_READ:
            begin
                if (pos_e >= len_e)
                    p_status = iale_pkg::ST_RANGE;
                else
                    p_rd = 1'b1;
            end
            iale_pkg::CMD_WRITE:
            begin
                if (pos_e >= len_e)
                begin
                    p_status = iale_pkg::ST_RANGE;
                end
                else
                begin
                    p_fptr = item_reg.position;
                    p_fcnt = iale_pkg::POS_W'(1);
                end
            end
            iale_pkg::CMD_CLEAR:
            begin
                p_len = '0;
            end
            iale_pkg::CMD_RESIZE:
            begin
                if (amt_e > cap_e)
                begin
                    p_status = iale_pkg::ST_FULL;
                end
                else
                begin
                    p_fptr = len_reg;
                    p_fcnt = (amt_e > len_e) ? item_reg.amount - len_reg : '0;
                    p_len  = item_reg.amount;
                end
            end
            default:
            begin
                p_status = iale_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            fptr_reg       <= '0;
            mcnt_reg       <= '0;
            fcnt_reg       <= '0;
            up_reg         <= 1'b0;
            rd_pending_reg <= 1'b0;
            rd_op_reg      <= 1'b0;
            status_reg     <= iale_pkg::ST_OK;
            rpos_reg       <= '0;
        end
        else if (cmd.plan)
        begin
            len_reg        <= p_len;
            src_reg        <= p_src;
            dst_reg        <= p_dst;
            fptr_reg       <= p_fptr;
            mcnt_reg       <= p_mcnt;
            fcnt_reg       <= p_fcnt;
            up_reg         <= p_up;
            rd_pending_reg <= p_rd;
            rd_op_reg      <= p_rd;
            status_reg     <= p_status;
            rpos_reg       <= p_pos;
        end
        else
        begin
            if (cmd.mem_rd)
                rd_pending_reg <= 1'b0;
            // Advance move pointers one word per write
            if (cmd.move_wr)
            begin
                src_reg  <= up_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                dst_reg  <= up_reg ? dst_reg + 1'b1 : dst_reg - 1'b1;
                mcnt_reg <= mcnt_reg - 1'b1;
            end
            if (cmd.fill_wr)
            begin
                fptr_reg <= fptr_reg + 1'b1;
                fcnt_reg <= fcnt_reg - 1'b1;
            end
        end
    end

    assign we    = cmd.move_wr | cmd.fill_wr;
    assign waddr = cmd.move_wr ? dst_reg[iale_pkg::ADDR_W-1:0] : fptr_reg[iale_pkg::ADDR_W-1:0];
    assign wdata = cmd.move_wr ? rdata_reg : item_reg.value;
    assign raddr = rd_pending_reg ? item_reg.position[iale_pkg::ADDR_W-1:0]
                                  : src_reg[iale_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.mem_rd)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!rsp_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.status          <= status_reg;
            rsp_reg.read_value      <= rd_op_reg ? rdata_reg : '0;
            rsp_reg.result_position <= rpos_reg;
            rsp_reg.length          <= len_reg;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign rsp             = rsp_reg;
    assign stat.rd_pending = rd_pending_reg;
    assign stat.moves_left = (mcnt_reg != '0);
    assign stat.fills_left = (fcnt_reg != '0);
    assign stat.out_free   = !out_valid_reg || !rsp_stall;

    `IALE_ASSERT_ALWAYS(a_len_in_cap, clk,
        {1'b0, len_reg} <= iale_pkg::EXT_W'(iale_pkg::CAPACITY))
    `IALE_ASSERT(a_one_writer, clk, rst_n, !(cmd.move_wr && cmd.fill_wr))
    `IALE_ASSERT(a_fill_counted, clk, rst_n, cmd.fill_wr |-> fcnt_reg != '0)
    `IALE_ASSERT(a_move_counted, clk, rst_n, cmd.move_wr |-> mcnt_reg != '0)

endmodule

// ----- hdl/iale_ctrl.sv -----
// ---------------------------------------------------------------------------
// iale_ctrl
// Sequencer: plan, read, move and fill steps, then hand over the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module iale_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  iale_pkg::dp_stat_t  stat,
    output iale_pkg::ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PLAN    = 3'd1;
    localparam logic [2:0] S_RUN     = 3'd2;
    localparam logic [2:0] S_RD      = 3'd3;
    localparam logic [2:0] S_MOVE_RD = 3'd4;
    localparam logic [2:0] S_MOVE_WR = 3'd5;
    localparam logic [2:0] S_FILL    = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (stat.rd_pending)
                    state_next = S_RD;
                else if (stat.moves_left)
                    state_next = S_MOVE_RD;
                else if (stat.fills_left)
                    state_next = S_FILL;
                else
                    state_next = S_DONE;
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_RUN;
            end
            S_MOVE_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_RUN;
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = S_RUN;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_stall = (state_reg != S_IDLE);

endmodule

// ----- hdl/indexed_array_list_engine_unit.sv -----
// Sequence: the command beat is captured and planned; a read command then reads the word
// store, each word moved by insert or erase is read and then written, and each word written
// by push, write, insert fill or resize fill takes one write; the result is then loaded
// into the output register once it is free. Only one command is in flight; the next
// beat is taken the cycle after the result is loaded into the output register, even
// while that result still waits. A move is one read then one write to the word store.
// Reset: length cleared at once; word contents stay undefined, no clearing pass.
// ---------------------------------------------------------------------------
// indexed_array_list_engine_unit
// Fixed-capacity ordered word list with push, pop, insert, erase, read,
// write, clear and resize; one result beat per command beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_array_list_engine_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  iale_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output iale_pkg::rsp_t rsp
);

    iale_pkg::ctrl_cmd_t cmd;
    iale_pkg::dp_stat_t  stat;

    // Sequencer: decides which step runs each cycle
    iale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage, pointers and result register
    iale_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ----- dv/tb.sv -----
// ---------------------------------------------------------------------------
// tb: array list engine testbench
// Drives command beats into the engine, predicts each response from a
// behavioural copy of the word list and compares every response field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    // Behavioural copy of the list plus the queue of predicted responses
    class list_scoreboard;
        logic [iale_pkg::WORD_WIDTH-1:0] words [iale_pkg::CAPACITY];
        int unsigned                     count;
        iale_pkg::rsp_t                  pending [$];
        int unsigned                     errors;

        function void clear_state();
            count = 0;
            for (int i = 0; i < iale_pkg::CAPACITY; i++)
                words[i] = '0;
        endfunction

        // Work out the response to one accepted command and queue it
        function void note_command(iale_pkg::req_t r);
            iale_pkg::rsp_t e;
            int unsigned    p, re, am, gap;
            p  = 32'(r.position);
            re = 32'(r.range_end);
            am = 32'(r.amount);
            e  = '0;
            e.status = iale_pkg::ST_OK;
            case (r.cmd)
                iale_pkg::CMD_PUSH:
                    if (count >= iale_pkg::CAPACITY) e.status = iale_pkg::ST_FULL;
                    else
                    begin
                        words[count] = r.value;
                        e.result_position = iale_pkg::POS_W'(count);
                        count++;
                    end
                iale_pkg::CMD_POP:
                    if (count == 0) e.status = iale_pkg::ST_EMPTY;
                    else count--;
                iale_pkg::CMD_INSERT:
                    if (p > count) e.status = iale_pkg::ST_RANGE;
                    else if (count + am > iale_pkg::CAPACITY) e.status = iale_pkg::ST_FULL;
                    else
                    begin
                        for (int i = count; i > p; i--)
                            words[i - 1 + am] = words[i - 1];
                        for (int i = 0; i < am; i++)
                            words[p + i] = r.value;
                        count += am;
                        e.result_position = iale_pkg::POS_W'(p);
                    end
                iale_pkg::CMD_ERASE_ONE:
                    if (p >= count) e.status = iale_pkg::ST_RANGE;
                    else
                    begin
                        for (int i = p; i + 1 < count; i++)
                            words[i] = words[i + 1];
                        count--;
                        e.result_position = iale_pkg::POS_W'(p);
                    end
                iale_pkg::CMD_ERASE_RANGE:
                    if (p > re || re > count) e.status = iale_pkg::ST_RANGE;
                    else
                    begin
                        gap = re - p;
                        for (int i = re; i < count; i++)
                            words[i - gap] = words[i];
                        count -= gap;
                        e.result_position = iale_pkg::POS_W'(p);
                    end
                iale_pkg::CMD_READ:
                    if (p >= count) e.status = iale_pkg::ST_RANGE;
                    else e.read_value = words[p];
                iale_pkg::CMD_WRITE:
                    if (p >= count) e.status = iale_pkg::ST_RANGE;
                    else words[p] = r.value;
                iale_pkg::CMD_CLEAR:
                    count = 0;
                iale_pkg::CMD_RESIZE:
                    if (am > iale_pkg::CAPACITY) e.status = iale_pkg::ST_FULL;
                    else
                    begin
                        for (int i = count; i < am; i++)
                            words[i] = r.value;
                        count = am;
                    end
                default: ;
            endcase
            e.length = iale_pkg::POS_W'(count);
            pending = {pending, e};
        endfunction

        function void check_response(iale_pkg::rsp_t a);
            iale_pkg::rsp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response %h", $realtime, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                $display("%0t: status exp %0d got %0d", $realtime, e.status, a.status);
                errors++;
            end
            if (a.read_value !== e.read_value)
            begin
                $display("%0t: read_value exp %h got %h", $realtime, e.read_value,
                         a.read_value);
                errors++;
            end
            if (a.result_position !== e.result_position)
            begin
                $display("%0t: result_position exp %0d got %0d", $realtime,
                         e.result_position, a.result_position);
                errors++;
            end
            if (a.length !== e.length)
            begin
                $display("%0t: length exp %0d got %0d", $realtime, e.length, a.length);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    iale_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    iale_pkg::rsp_t rsp;

    list_scoreboard sb;
    int unsigned    burst_left;
    bit             stall_mode;

    indexed_array_list_engine_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: end the run as failed if it hangs
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Receiver: alternate between quiet stretches and random stalling
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode = ~stall_mode;
            rsp_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    // Check every response beat that the engine hands over
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
    end

    // Send one command beat; hold it until taken, with bursty gaps in front
    task automatic send_beat(iale_pkg::req_t r);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
        sb.note_command(r);
    endtask

    task automatic send_cmd(logic [3:0] c, int p, int re, int am, logic [31:0] v);
        iale_pkg::req_t r;
        r.cmd       = c;
        r.position  = iale_pkg::POS_W'(p);
        r.range_end = iale_pkg::POS_W'(re);
        r.amount    = iale_pkg::POS_W'(am);
        r.value     = v;
        send_beat(r);
    endtask

    // Wait until every predicted response has arrived
    task automatic drain();
        int unsigned guard;
        guard = 0;
        req_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    // Mostly legal commands sized against the current length, with some noise
    task automatic random_beat();
        iale_pkg::req_t r;
        int unsigned    n;
        n = sb.count;
        r.cmd   = 4'($urandom_range(0, 8));
        r.value = $urandom;
        if ($urandom_range(0, 9) == 0)
        begin
            r.cmd       = 4'($urandom);
            r.position  = iale_pkg::POS_W'($urandom);
            r.range_end = iale_pkg::POS_W'($urandom);
            r.amount    = iale_pkg::POS_W'($urandom);
        end
        else
        begin
            r.position  = iale_pkg::POS_W'($urandom_range(0, n + 1));
            r.range_end = iale_pkg::POS_W'($urandom_range(32'(r.position), n + 1));
            r.amount    = ($urandom_range(0, 7) == 0)
                          ? iale_pkg::POS_W'($urandom_range(0, 66))
                          : iale_pkg::POS_W'($urandom_range(0, 4));
            if (r.cmd == iale_pkg::CMD_RESIZE && $urandom_range(0, 1))
                r.amount = iale_pkg::POS_W'($urandom_range(n > 3 ? n - 3 : 0, n + 3));
        end
        send_beat(r);
    endtask

    initial
    begin
        sb = new();
        sb.clear_state();
        stall_mode = 1'b0;
        burst_left = 0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-list corner cases first
        send_cmd(iale_pkg::CMD_POP, 0, 0, 0, 0);
        send_cmd(iale_pkg::CMD_ERASE_ONE, 0, 0, 0, 0);
        send_cmd(iale_pkg::CMD_READ, 0, 0, 0, 0);
        send_cmd(iale_pkg::CMD_WRITE, 0, 0, 0, 32'hffff_ffff);
        send_cmd(iale_pkg::CMD_INSERT, 1, 0, 1, 5);
        send_cmd(iale_pkg::CMD_INSERT, 0, 0, 0, 5);
        send_cmd(iale_pkg::CMD_ERASE_RANGE, 0, 0, 0, 0);
        send_cmd(iale_pkg::CMD_PUSH, 0, 0, 0, 32'hffff_ffff);
        send_cmd(iale_pkg::CMD_PUSH, 0, 0, 0, 32'h0);
        send_cmd(iale_pkg::CMD_INSERT, 1, 0, 3, 32'ha5a5_5a5a);
        send_cmd(iale_pkg::CMD_READ, 2, 0, 0, 0);
        send_cmd(iale_pkg::CMD_WRITE, 4, 0, 0, 32'h1234_5678);
        send_cmd(iale_pkg::CMD_ERASE_RANGE, 3, 2, 0, 0);
        send_cmd(iale_pkg::CMD_ERASE_RANGE, 1, 6, 0, 0);
        send_cmd(iale_pkg::CMD_ERASE_RANGE, 1, 3, 0, 0);
        send_cmd(iale_pkg::CMD_ERASE_ONE, 0, 0, 0, 0);
        send_cmd(4'd15, 127, 127, 127, 32'hffff_ffff);
        send_cmd(iale_pkg::CMD_RESIZE, 0, 0, 65, 1);
        send_cmd(iale_pkg::CMD_RESIZE, 0, 0, 64, 32'h5555_aaaa);
        send_cmd(iale_pkg::CMD_PUSH, 0, 0, 0, 7);
        send_cmd(iale_pkg::CMD_INSERT, 0, 0, 1, 7);
        send_cmd(iale_pkg::CMD_READ, 63, 0, 0, 0);
        send_cmd(iale_pkg::CMD_READ, 64, 0, 0, 0);
        send_cmd(iale_pkg::CMD_RESIZE, 0, 0, 2, 0);
        send_cmd(iale_pkg::CMD_CLEAR, 127, 127, 127, 0);

        // Pause until the engine has answered everything
        drain();

        for (int i = 0; i < 450; i++)
            random_beat();
        drain();

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/iale_pkg.sv
hdl/iale_dp.sv
hdl/iale_ctrl.sv
hdl/indexed_array_list_engine_unit.sv
dv/tb.sv
